### src/fba_pkg.sv
package fba_pkg;

  // build-time defaults
  localparam int unsigned MaxBlocks = 256;
  localparam int unsigned AddrBits  = 32;
  localparam int unsigned AlignUnit = 8;

  // effective block size is 8..65536 bytes
  localparam int unsigned BlockW = 17;

  // allocated addresses are wrapped to the address space, then to 32 bits
  localparam logic [31:0] ResMask = (AddrBits >= 32) ? 32'hFFFF_FFFF
                                                      : 32'((64'd1 << AddrBits) - 64'd1);

  // configuration register indexes
  localparam logic [1:0] RegBase  = 2'd0;
  localparam logic [1:0] RegBytes = 2'd1;
  localparam logic [1:0] RegCount = 2'd2;

  // request modes
  localparam logic [1:0] ModeAlloc    = 2'd0;
  localparam logic [1:0] ModeFree     = 2'd1;
  localparam logic [1:0] ModeResize   = 2'd2;
  localparam logic [1:0] ModeContains = 2'd3;

  // response status codes
  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatSizeRej = 2'd1;
  localparam logic [1:0] StatEmpty   = 2'd2;
  localparam logic [1:0] StatOutside = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] request_size;
    logic [31:0] address;
  } fba_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_address;
    logic        contained;
  } fba_rsp_t;

endpackage

### src/fba_if.sv
interface fba_req_if import fba_pkg::*; ();
  logic     valid;
  logic     ready;
  fba_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fba_rsp_if import fba_pkg::*; ();
  logic     valid;
  logic     ready;
  fba_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/fba_mem.sv
module fba_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 9,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/fba_div.sv
module fba_div import fba_pkg::*; #(
  parameter int unsigned QW = 8,
  parameter int unsigned RW = 26,
  localparam int unsigned CW = $clog2(QW + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RW-1:0]     dividend_i,
  input  logic [BlockW-1:0] divisor_i,
  output logic              done_o,
  output logic [QW-1:0]     quotient_o
);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [RW-1:0] dsr_q, dsr_d;
  logic [QW-1:0] quo_q, quo_d;
  logic          ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    ge     = (rem_q >= dsr_q);
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(QW);
      rem_d  = dividend_i;
      dsr_d  = RW'(divisor_i) << (QW - 1);
      quo_d  = '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsr_q;
      end
      dsr_d = dsr_q >> 1;
      quo_d = QW'({quo_q, ge});
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### src/fixed_block_pool_allocator_core.sv
// Fixed-size block pool allocator with a LIFO free list.
// req_i carries one request per transaction (mode, request_size, address);
// rsp_o returns exactly one response per request, in order (status,
// result_address, contained). Both are valid/ready channels.
// Configuration (base address, block size, block count) is written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write it only while the block is idle, which
// the block itself does not enforce; each write to a known register rebuilds the free list.
// The next-index table sits in a single-port-write, registered-read memory.
// A contains, resize, null free or rejected request passes through SEval and
// SDone to the output register; an allocate passes SEval, SAlloc and SDone;
// a free of an in-pool block waits in SDiv between SEval and SDone for the one
// bit per cycle offset divider. One request is in flight at a time; the next is
// taken at the first edge after the previous response is parked in the
// output register.
// Reset and every rebuild run a fill pass over all MAX_BLOCKS table entries,
// one entry per cycle, during which req_i.ready stays low.
// If the receiver stalls, the response waits in the output register; a
// finished response behind it holds the engine until the register drains.
module fixed_block_pool_allocator_core import fba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MaxBlocks
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  fba_req_if.sink      req_i,
  fba_rsp_if.source    rsp_o
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned QW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned LIM_W = BlockW + IDX_W;
  localparam int unsigned XW    = ((LIM_W > 33) ? LIM_W : 33) + 1;
  localparam int unsigned PW    = BlockW + QW;
  localparam logic [IDX_W-1:0] NullIdx = IDX_W'(MAX_BLOCKS);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_BLOCKS - 1);

  // state codes
  localparam logic [2:0] SSweep = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SEval  = 3'd2;
  localparam logic [2:0] SAlloc = 3'd3;
  localparam logic [2:0] SDiv   = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  sweep_q, sweep_d;
  logic [31:0]       base_q, base_d;
  logic [15:0]       bytes_q, bytes_d;
  logic [8:0]        count_q, count_d;
  logic [LIM_W-1:0]  limit_q;
  fba_req_t          item_q;
  logic [PW-1:0]     prod_q, prod_d;
  fba_rsp_t          res_q, res_d;
  fba_rsp_t          rsp_q, rsp_d;
  logic              rsp_valid_q, rsp_valid_d;

  logic [BlockW-1:0] eb_w;
  logic [IDX_W-1:0]  ec_w;
  logic [IDX_W:0]    sweep_nxt;
  logic              addr_in_pool;
  logic              accept;

  logic              mem_we;
  logic [QW-1:0]     mem_waddr;
  logic [IDX_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]  mem_rdata;

  logic              div_start;
  logic              div_done;
  logic [QW-1:0]     div_quo;

  // effective block size and count
  always_comb begin
    if (bytes_q < 16'(AlignUnit)) begin
      eb_w = BlockW'(AlignUnit);
    end else begin
      eb_w = (BlockW'(bytes_q) + BlockW'(AlignUnit - 1)) & ~BlockW'(AlignUnit - 1);
    end
    if (32'(count_q) > 32'(MAX_BLOCKS)) begin
      ec_w = NullIdx;
    end else begin
      ec_w = IDX_W'(count_q);
    end
  end

  // pool range test
  always_comb begin
    logic [XW-1:0] addr_x;
    logic [XW-1:0] base_x;
    addr_x = XW'(item_q.address);
    base_x = XW'(base_q);
    addr_in_pool = (addr_x >= base_x) && ((addr_x - base_x) < XW'(limit_q));
  end

  assign accept    = req_i.valid && req_i.ready;
  assign sweep_nxt = {1'b0, sweep_q} + (IDX_W + 1)'(1);

  // sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    sweep_d     = sweep_q;
    base_d      = base_q;
    bytes_d     = bytes_q;
    count_d     = count_q;
    prod_d      = prod_q;
    res_d       = res_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    mem_we      = 1'b0;
    mem_waddr   = sweep_q[QW-1:0];
    mem_wdata   = NullIdx;
    div_start   = 1'b0;

    unique case (state_q)
      SSweep: begin
        mem_we    = 1'b1;
        mem_wdata = (sweep_nxt < (IDX_W + 1)'(ec_w)) ? IDX_W'(sweep_nxt) : NullIdx;
        sweep_d   = IDX_W'(sweep_nxt);
        if (sweep_q == LastIdx) begin
          state_d = SIdle;
          head_d  = (ec_w != '0) ? '0 : NullIdx;
        end
      end
      SIdle: begin
        if (accept) begin
          state_d = SEval;
        end
      end
      SEval: begin
        res_d.status         = StatOk;
        res_d.result_address = '0;
        res_d.contained      = addr_in_pool;
        state_d              = SDone;
        unique case (item_q.mode)
          ModeAlloc: begin
            if (item_q.request_size == '0 || item_q.request_size > 32'(eb_w)) begin
              res_d.status = StatSizeRej;
            end else if (head_q == NullIdx) begin
              res_d.status = StatEmpty;
            end else begin
              prod_d  = PW'(eb_w) * PW'(head_q[QW-1:0]);
              state_d = SAlloc;
            end
          end
          ModeFree: begin
            if (item_q.address != '0) begin
              if (!addr_in_pool) begin
                res_d.status = StatOutside;
              end else begin
                div_start = 1'b1;
                state_d   = SDiv;
              end
            end
          end
          ModeResize: begin
            if (item_q.address != '0 && !addr_in_pool) begin
              res_d.status = StatOutside;
            end else if (item_q.request_size > 32'(eb_w)) begin
              res_d.status = StatSizeRej;
            end else begin
              res_d.result_address = item_q.address;
            end
          end
          default: begin
          end
        endcase
      end
      SAlloc: begin
        // pop: head moves to the entry read at the old head
        head_d               = mem_rdata;
        res_d.result_address = ResMask & 32'(XW'(base_q) + XW'(prod_q));
        state_d              = SDone;
      end
      SDiv: begin
        // push: freed block points at the old head
        if (div_done) begin
          mem_we    = 1'b1;
          mem_waddr = div_quo;
          mem_wdata = head_q;
          head_d    = IDX_W'(div_quo);
          state_d   = SDone;
        end
      end
      SDone: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_d       = res_q;
          rsp_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SSweep;
        sweep_d = '0;
      end
    endcase

    // configuration write to a known register restarts the table rebuild
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBase:  base_d  = cfg_data_i;
        RegBytes: bytes_d = cfg_data_i[15:0];
        RegCount: count_d = cfg_data_i[8:0];
        default: begin
        end
      endcase
      if (cfg_idx_i == RegBase || cfg_idx_i == RegBytes || cfg_idx_i == RegCount) begin
        state_d = SSweep;
        sweep_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SSweep;
      head_q      <= '0;
      sweep_q     <= '0;
      base_q      <= '0;
      bytes_q     <= 16'd8;
      count_q     <= 9'd256;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      sweep_q     <= sweep_d;
      base_q      <= base_d;
      bytes_q     <= bytes_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= req_i.data;
    end
    limit_q <= LIM_W'(eb_w) * LIM_W'(ec_w);
    prod_q  <= prod_d;
    res_q   <= res_d;
    rsp_q   <= rsp_d;
  end

  fba_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (head_q[QW-1:0]),
    .rdata_o (mem_rdata)
  );

  fba_div #(
    .QW (QW),
    .RW (LIM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (LIM_W'(item_q.address - base_q)),
    .divisor_i  (eb_w),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign req_i.ready = (state_q == SIdle);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // head is a block index or the null marker
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= NullIdx)
    else $error("free list head out of range");

  // one request in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("request taken while another is in flight");

  // divider finishes only while a free is waiting on it
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == SDiv)
    else $error("divider done outside free sequence");

  // a new response comes only from a finished request
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q) == SDone)
    else $error("response raised without a finished request");

endmodule

### sim/fba_pool_checker.sv
`timescale 1ns / 100ps

module fba_pool_checker import fba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  fba_req_if          req_mon,
  fba_rsp_if          rsp_mon,
  output int unsigned outstanding_o,
  output int unsigned mismatches_o
);

  localparam logic [8:0] NullIdx = 9'(MaxBlocks);

  // mirrored configuration and free list
  logic [31:0] base_q;
  logic [15:0] bytes_q;
  logic [8:0]  count_q;
  logic [8:0]  next_free [MaxBlocks];
  logic [8:0]  head_q;

  fba_rsp_t    awaited_rsp_q [$];
  int unsigned mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  // block size raised to 8 and rounded up to a multiple of 8
  function automatic logic [16:0] block_span();
    logic [16:0] b;
    b = (bytes_q < 16'd8) ? 17'd8 : {1'b0, bytes_q};
    return (b + 17'd7) & ~17'd7;
  endfunction

  // block count saturated to the built capacity
  function automatic logic [8:0] blocks_in_use();
    return (count_q > 9'(MaxBlocks)) ? 9'(MaxBlocks) : count_q;
  endfunction

  // free list back in block order
  function automatic void relink_free_list();
    logic [8:0] n;
    n = blocks_in_use();
    for (int i = 0; i < MaxBlocks; i++) begin
      next_free[i] = (i + 1 < n) ? 9'(i + 1) : NullIdx;
    end
    head_q = (n > 0) ? 9'd0 : NullIdx;
  endfunction

  // pool range check, upper bound without wrap
  function automatic logic in_pool(logic [31:0] addr);
    logic [63:0] lo;
    logic [63:0] hi;
    lo = {32'b0, base_q};
    hi = lo + 64'(block_span()) * 64'(blocks_in_use());
    return ({32'b0, addr} >= lo) && ({32'b0, addr} < hi);
  endfunction

  // response to one request, free list updated on the way
  function automatic fba_rsp_t pool_outcome(fba_req_t req);
    fba_rsp_t    rsp;
    logic [16:0] eb;
    logic [8:0]  idx;
    logic [63:0] slot_addr;
    logic [63:0] offset;
    eb = block_span();
    rsp.status = StatOk;
    rsp.result_address = '0;
    rsp.contained = in_pool(req.address);
    case (req.mode)
      ModeAlloc: begin
        if (req.request_size == 32'd0 || req.request_size > {15'b0, eb}) begin
          rsp.status = StatSizeRej;
        end else if (head_q >= 9'(MaxBlocks)) begin
          rsp.status = StatEmpty;
        end else begin
          idx = head_q;
          head_q = next_free[idx];
          slot_addr = {32'b0, base_q} + 64'(idx) * 64'(eb);
          rsp.result_address = slot_addr[31:0] & ResMask;
        end
      end
      ModeFree: begin
        if (req.address != 32'd0) begin
          if (!rsp.contained) begin
            rsp.status = StatOutside;
          end else begin
            offset = ({32'b0, req.address} - {32'b0, base_q}) / 64'(eb);
            if (offset < 64'(MaxBlocks)) begin
              next_free[offset[7:0]] = head_q;
              head_q = offset[8:0];
            end
          end
        end
      end
      ModeResize: begin
        if (req.address != 32'd0 && !rsp.contained) begin
          rsp.status = StatOutside;
        end else if (req.request_size > {15'b0, eb}) begin
          rsp.status = StatSizeRej;
        end else begin
          rsp.result_address = req.address;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("mismatch on %s at %0t: expected %h, got %h", name, $realtime, want, got);
      end
    end
  endfunction

  // follow config writes, predict on request, compare on response
  always @(posedge clk_i or negedge rst_ni) begin
    fba_rsp_t want;
    logic     known_reg;
    if (!rst_ni) begin
      base_q = '0;
      bytes_q = 16'd8;
      count_q = 9'(MaxBlocks);
      relink_free_list();
      awaited_rsp_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        known_reg = 1'b1;
        case (cfg_idx_i)
          RegBase:  base_q = cfg_data_i;
          RegBytes: bytes_q = cfg_data_i[15:0];
          RegCount: count_q = cfg_data_i[8:0];
          default:  known_reg = 1'b0;
        endcase
        if (known_reg) relink_free_list();
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_rsp_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("unexpected response at %0t: %h", $realtime, rsp_mon.data);
          end
        end else begin
          want = awaited_rsp_q.pop_front();
          check_field("status", 32'(want.status), 32'(rsp_mon.data.status));
          check_field("result_address", want.result_address, rsp_mon.data.result_address);
          check_field("contained", 32'(want.contained), 32'(rsp_mon.data.contained));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        awaited_rsp_q.push_back(pool_outcome(req_mon.data));
      end
      outstanding_o <= awaited_rsp_q.size();
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import fba_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned StallCycles  = 400;
  localparam int unsigned NumPhases    = 9;
  localparam int unsigned RandPerPhase = 180;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  logic        calm;
  logic        hold_go;
  int unsigned cycles = 0;
  int unsigned outstanding;
  int unsigned mismatches;

  // stimulus view of the pool
  logic [31:0] cur_base = '0;
  logic [16:0] cur_eb = 17'd8;
  logic [8:0]  cur_ec = 9'd256;
  logic [1:0]  sent_modes [$];
  logic [31:0] live_blocks [$];

  fba_req_if req_if ();
  fba_rsp_if rsp_if ();

  fixed_block_pool_allocator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  fba_pool_checker u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_mon       (req_if),
    .rsp_mon       (rsp_if),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  always #5ns clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // response side: random stalls, one long hold-off, calm stretch
  initial begin
    int unsigned held;
    held = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && held < StallCycles) begin
        rsp_if.ready <= 1'b0;
        held++;
      end else if (calm) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= 8);
      end
    end
  end

  // remember granted blocks so that frees mostly hit live ones
  always @(posedge clk_i) begin
    logic [1:0] mode;
    if (rsp_if.valid && rsp_if.ready && sent_modes.size() > 0) begin
      mode = sent_modes.pop_front();
      if (mode == ModeAlloc && rsp_if.data.status == StatOk) begin
        live_blocks.push_back(rsp_if.data.result_address);
      end
    end
  end

  // register write, then wait out the list rebuild
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] base, input logic [15:0] bytes,
                           input logic [8:0] count);
    write_reg(RegBase, base);
    write_reg(RegBytes, {16'b0, bytes});
    write_reg(RegCount, {23'b0, count});
    cur_base = base;
    cur_eb = (bytes < 16'd8) ? 17'd8 : (({1'b0, bytes} + 17'd7) & ~17'd7);
    cur_ec = (count > 9'd256) ? 9'd256 : count;
  endtask

  // one request transaction with random idle cycles ahead of it
  task automatic send_item(input logic [1:0] mode, input logic [31:0] size,
                           input logic [31:0] addr);
    fba_req_t item;
    item.mode = mode;
    item.request_size = size;
    item.address = addr;
    while (!calm && $urandom_range(99) < 8) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= item;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent_modes.push_back(mode);
  endtask

  // wait until every response is back
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return {15'b0, cur_eb};
      2: return {15'b0, cur_eb} + 32'd1;
      3: return $urandom;
      4: return 32'hFFFF_FFFF;
      default: return 32'($urandom_range(1, cur_eb));
    endcase
  endfunction

  // block starts mostly, plus null, range edges and wild values
  function automatic logic [31:0] pick_addr();
    logic [63:0] lim;
    logic [31:0] blk;
    lim = {32'b0, cur_base} + 64'(cur_eb) * 64'(cur_ec);
    blk = (cur_ec == 0) ? cur_base
        : cur_base + 32'($urandom_range(cur_ec - 1)) * {15'b0, cur_eb};
    case ($urandom_range(19))
      0: return 32'd0;
      1, 2: return $urandom;
      3: return cur_base - 32'd1;
      4: return lim[31:0];
      5: return lim[31:0] - 32'd1;
      6: return blk + 32'($urandom_range(cur_eb - 1));
      default: return blk;
    endcase
  endfunction

  // mostly alloc and free of live blocks, the rest queries and noise
  task automatic random_item();
    int unsigned pick;
    int unsigned slot;
    logic [31:0] a;
    pick = $urandom_range(99);
    if (pick >= 35 && pick < 65 && live_blocks.size() > 0) begin
      slot = $urandom_range(live_blocks.size() - 1);
      a = live_blocks[slot];
      live_blocks.delete(slot);
      if ($urandom_range(4) == 0) a = a + 32'($urandom_range(cur_eb - 1));
      send_item(ModeFree, $urandom, a);
    end else if (pick < 65) begin
      send_item(ModeAlloc,
                ($urandom_range(9) < 8) ? 32'($urandom_range(1, cur_eb)) : pick_size(),
                pick_addr());
    end else if (pick < 70) begin
      send_item(ModeFree, $urandom, pick_addr());
    end else if (pick < 85) begin
      send_item(ModeResize, pick_size(), pick_addr());
    end else begin
      send_item(ModeContains, $urandom, pick_addr());
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= RegBase;
    cfg_data_i <= '0;
    req_if.valid <= 1'b0;
    req_if.data <= '0;
    calm <= 1'b0;
    hold_go <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      // new pool layout while idle
      if (p > 0) begin
        drain();
        live_blocks.delete();
        case (p)
          1: configure(32'hFFFF_FFFF, 16'hFFFF, 9'd511);
          2: configure(32'h0000_1000, 16'd8, 9'd0);
          3: configure(32'h1000_0000, 16'd1, 9'd1);
          4: configure(32'h0040_0000, 16'd9, 9'd4);
          5: configure($urandom, 16'($urandom_range(1, 65535)), 9'($urandom_range(1, 256)));
          6: configure(32'h8000_0000, 16'd24, 9'd256);
          7: configure(32'h0000_1000, 16'd100, 9'd37);
          default: configure(32'hFFFF_FFF8, 16'd8, 9'd2);
        endcase
      end
      calm <= (p == 6);
      hold_go <= (p == 7);

      // directed corners
      case (p)
        0: begin
          send_item(ModeAlloc, 32'd0, 32'd0);
          send_item(ModeAlloc, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          send_item(ModeAlloc, 32'd9, 32'd0);
          send_item(ModeAlloc, 32'd8, 32'd0);
          send_item(ModeAlloc, 32'd1, 32'd0);
          send_item(ModeFree, 32'd0, 32'd0);
          send_item(ModeFree, 32'd0, 32'd2048);
          // misaligned free pushes the holding block, then a double free
          send_item(ModeFree, 32'd0, 32'd13);
          send_item(ModeFree, 32'd0, 32'd8);
          send_item(ModeAlloc, 32'd8, 32'd0);
          send_item(ModeAlloc, 32'd8, 32'd0);
          send_item(ModeResize, 32'd8, 32'd16);
          send_item(ModeResize, 32'd9, 32'd16);
          send_item(ModeResize, 32'd0, 32'hFFFF_FFFF);
          send_item(ModeContains, 32'd0, 32'd2047);
        end
        1: begin
          // largest blocks, addresses wrap past the top
          send_item(ModeAlloc, 32'd65536, 32'd0);
          send_item(ModeAlloc, 32'd65537, 32'd0);
          send_item(ModeAlloc, 32'd1, 32'hFFFF_FFFF);
          send_item(ModeFree, 32'd0, 32'hFFFF_FFFF);
          send_item(ModeContains, 32'd0, 32'hFFFF_FFFF);
        end
        2: begin
          // empty pool
          send_item(ModeAlloc, 32'd1, 32'h0000_1000);
          send_item(ModeFree, 32'd0, 32'h0000_1000);
        end
        3: begin
          send_item(ModeAlloc, 32'd8, 32'd0);
          send_item(ModeAlloc, 32'd8, 32'd0);
        end
        default: ;
      endcase

      repeat (RandPerPhase) random_item();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
